### hw/rtl/pdlr_pkg.sv
package pdlr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 19;
   localparam int COUNT_W     = 3;
   localparam int RATE_W      = 18;
   localparam int STEP_W      = 24;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

   // reciprocal of the channel count, ceil(2^21 / n); exact for |sum| < 2^18
   localparam int RECIP_W = 22;
   localparam int AVG_SH  = 21;
   localparam logic [RECIP_W-1:0] RECIP_TABLE [8] = '{
      22'd0, 22'd2097152, 22'd1048576, 22'd699051,
      22'd524288, 22'd419431, 22'd349526, 22'd299594
   };

   localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 3'd1;
   localparam logic [RATE_W-1:0]  RST_SOURCE_RATE   = 18'd32000;
   localparam logic [RATE_W-1:0]  RST_OUTPUT_RATE   = 18'd48000;
   localparam logic               RST_SIXTEEN_BIT   = 1'b1;

   typedef enum logic [1:0] {
      REG_CHANNEL_COUNT,
      REG_SOURCE_RATE,
      REG_OUTPUT_RATE,
      REG_SIXTEEN_BIT
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIV_FIN,
      ST_AVG_MUL,
      ST_AVG_FIN,
      ST_HOLD,
      ST_INT_MUL,
      ST_INT_EMIT,
      ST_FIN_LOOP,
      ST_END
   } state_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_raw;
      logic                final_frame;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mono_sample;
      logic                       run_last;
      logic                       cue_last;
   } rsp_type;

endpackage

### hw/rtl/pcm_downmix_linear_resampler.sv
// Mono downmix and linear sample-rate converter for one PCM cue at a time.
// req_* carries one interleaved sample per transfer (valid/ready); final_frame
// on a closing sample marks the cue's last frame. rsp_* returns resampled mono
// samples, run_last on the last one caused by a request and cue_last on the
// last one of the cue. csr_* is an APB-style port for channel count, rates
// and sample format; write it only while the block is idle.
// Per request: a sample that does not close a frame is only summed. A
// frame-closing sample runs the channel average and, past the first frame
// of a cue, one interpolation per output position inside the frame, plus
// the held-sample outputs on the final frame. The multiplier is shared:
// one pass for the channel average, one per position. The first sample of a
// cue also runs the step divider, one quotient bit a cycle. req_ready is low
// while busy.
// Results pass through a one-deep pending stage and an output register; a
// stalled receiver holds the sequencer at its next result, never drops one.
// Synchronous reset restores the register defaults and clears control state.
module pcm_downmix_linear_resampler #(
   parameter int PHASE_FRAC_BITS = 16,
   parameter int MAX_UPSAMPLE    = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pdlr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pdlr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pdlr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pdlr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pdlr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int F     = PHASE_FRAC_BITS;
   localparam int PH_W  = (F + 2 > 25) ? F + 2 : 25;
   localparam int DV_W  = pdlr_pkg::RATE_W + F;
   localparam int DC_W  = $clog2(DV_W);
   localparam int MB    = (F > pdlr_pkg::RECIP_W) ? F : pdlr_pkg::RECIP_W;
   localparam int P_W   = pdlr_pkg::SUM_W + MB + 1;
   localparam int SW    = pdlr_pkg::SAMPLE_W;
   localparam int RW    = pdlr_pkg::RATE_W;
   localparam int STW   = pdlr_pkg::STEP_W;

   localparam logic [PH_W-1:0] ONE     = PH_W'(1) << F;
   localparam logic [PH_W-1:0] TWO_ONE = PH_W'(1) << (F + 1);
   localparam logic [STW-1:0]  STEP_LO = STW'((64'd1 << F) / MAX_UPSAMPLE);
   localparam logic signed [P_W-1:0] INT_BIAS = (P_W'(1) << F) - P_W'(1);
   localparam logic signed [P_W-1:0] AVG_BIAS = (P_W'(1) << pdlr_pkg::AVG_SH) - P_W'(1);

   // control state
   pdlr_pkg::state_type state_ff, state_in;
   logic [pdlr_pkg::COUNT_W-1:0] cfg_count_ff, cfg_count_in;
   logic [RW-1:0]  cfg_src_ff, cfg_src_in;
   logic [RW-1:0]  cfg_out_ff, cfg_out_in;
   logic           cfg_sixteen_ff, cfg_sixteen_in;
   logic signed [pdlr_pkg::SUM_W-1:0] ch_sum_ff, ch_sum_in;
   logic [pdlr_pkg::COUNT_W-1:0] ch_idx_ff, ch_idx_in;
   logic signed [SW-1:0] prev_ff, prev_in;
   logic           have_prev_ff, have_prev_in;
   logic [PH_W-1:0] phase_ff, phase_in;
   logic           hold_valid_ff, hold_valid_in;
   logic [pdlr_pkg::RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic           pend_valid_ff, pend_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           ovf_ff, ovf_in;
   logic [DC_W-1:0] div_cnt_ff, div_cnt_in;

   // payload
   logic [STW-1:0] step_ff, step_in;
   logic signed [SW-1:0] hold_value_ff, hold_value_in;
   logic [PH_W-1:0] hold_slack_ff, hold_slack_in;
   logic           fin_ff, fin_in;
   logic           frame_done_ff, frame_done_in;
   logic signed [SW-1:0] cur_ff, cur_in;
   logic signed [SW-1:0] pend_value_ff, pend_value_in;
   logic [DV_W-1:0] dv_ff, dv_in;
   logic [RW:0]    rem_ff, rem_in;
   logic [STW-1:0] quo_ff, quo_in;
   logic signed [P_W-1:0] product_ff, product_in;
   pdlr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // datapath
   logic           out_free, push_ok, cfg_usable, start_step, frame_end;
   logic signed [SW-1:0] sample_s;
   logic signed [pdlr_pkg::SUM_W-1:0] sum_new;
   logic [pdlr_pkg::COUNT_W:0] idx_new;
   logic [PH_W-1:0] need;
   logic [RW:0]    div_shift, div_rem;
   logic           div_ge;
   logic signed [pdlr_pkg::SUM_W-1:0] mul_a;
   logic [MB-1:0]  mul_b;
   logic signed [SW:0] diff;
   logic signed [P_W-1:0] avg_adj, avg_shr, int_adj, int_shr;
   logic [SW+1:0]  interp_sum;
   logic signed [SW-1:0] interp_val;
   logic           emit_req, emit_push, end_push;
   logic signed [SW-1:0] emit_val;
   logic           csr_write;
   pdlr_pkg::reg_idx_type csr_idx;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign push_ok    = !pend_valid_ff || out_free;
   assign cfg_usable = (cfg_count_ff != '0) && (cfg_src_ff != '0);
   assign start_step = !have_prev_ff && (ch_idx_ff == '0);
   assign need       = phase_ff + PH_W'(step_ff);

   // unsigned bytes recentre to (byte - 128) * 256
   assign sample_s = cfg_sixteen_ff ? req_data.sample_raw
                   : {~req_data.sample_raw[7], req_data.sample_raw[6:0], 8'h00};
   assign sum_new   = ch_sum_ff + {{(pdlr_pkg::SUM_W - SW){sample_s[SW-1]}}, sample_s};
   assign idx_new   = {1'b0, ch_idx_ff} + 4'd1;
   assign frame_end = idx_new >= {1'b0, cfg_count_ff};

   // restoring divider, one quotient bit per cycle
   assign div_shift = {rem_ff[RW-1:0], dv_ff[DV_W-1]};
   assign div_ge    = div_shift >= {1'b0, cfg_out_ff};
   assign div_rem   = div_ge ? div_shift - {1'b0, cfg_out_ff} : div_shift;

   // shared multiplier, both uses truncate toward zero after the shift
   assign product_in = P_W'(mul_a) * P_W'($signed({1'b0, mul_b}));
   assign avg_adj    = product_ff + (product_ff[P_W-1] ? AVG_BIAS : '0);
   assign avg_shr    = avg_adj >>> pdlr_pkg::AVG_SH;
   assign int_adj    = product_ff + (product_ff[P_W-1] ? INT_BIAS : '0);
   assign int_shr    = int_adj >>> F;
   assign diff       = {cur_ff[SW-1], cur_ff} - {prev_ff[SW-1], prev_ff};
   assign interp_sum = {{2{prev_ff[SW-1]}}, prev_ff} + int_shr[SW+1:0];
   assign interp_val = interp_sum[SW-1:0];

   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx   = pdlr_pkg::reg_idx_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_idx)
         pdlr_pkg::REG_CHANNEL_COUNT: csr_prdata = pdlr_pkg::CSR_DATA_W'(cfg_count_ff);
         pdlr_pkg::REG_SOURCE_RATE:   csr_prdata = pdlr_pkg::CSR_DATA_W'(cfg_src_ff);
         pdlr_pkg::REG_OUTPUT_RATE:   csr_prdata = pdlr_pkg::CSR_DATA_W'(cfg_out_ff);
         pdlr_pkg::REG_SIXTEEN_BIT:   csr_prdata = pdlr_pkg::CSR_DATA_W'(cfg_sixteen_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      cfg_count_in   = cfg_count_ff;
      cfg_src_in     = cfg_src_ff;
      cfg_out_in     = cfg_out_ff;
      cfg_sixteen_in = cfg_sixteen_ff;
      ch_sum_in      = ch_sum_ff;
      ch_idx_in      = ch_idx_ff;
      prev_in        = prev_ff;
      have_prev_in   = have_prev_ff;
      phase_in       = phase_ff;
      hold_valid_in  = hold_valid_ff;
      res_cnt_in     = res_cnt_ff;
      pend_valid_in  = pend_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      ovf_in         = ovf_ff;
      div_cnt_in     = div_cnt_ff;
      step_in        = step_ff;
      hold_value_in  = hold_value_ff;
      hold_slack_in  = hold_slack_ff;
      fin_in         = fin_ff;
      frame_done_in  = frame_done_ff;
      cur_in         = cur_ff;
      pend_value_in  = pend_value_ff;
      dv_in          = dv_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      rsp_data_in    = rsp_data_ff;
      mul_a          = '0;
      mul_b          = '0;
      emit_req       = 1'b0;
      emit_val       = '0;
      emit_push      = 1'b0;
      end_push       = 1'b0;
      req_ready      = (state_ff == pdlr_pkg::ST_IDLE);

      if (csr_write) begin
         unique case (csr_idx)
            pdlr_pkg::REG_CHANNEL_COUNT: cfg_count_in = csr_pwdata[pdlr_pkg::COUNT_W-1:0];
            pdlr_pkg::REG_SOURCE_RATE:   cfg_src_in = csr_pwdata[RW-1:0];
            pdlr_pkg::REG_OUTPUT_RATE:   cfg_out_in = csr_pwdata[RW-1:0];
            pdlr_pkg::REG_SIXTEEN_BIT:   cfg_sixteen_in = csr_pwdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         pdlr_pkg::ST_IDLE: begin
            if (req_valid && cfg_usable) begin
               res_cnt_in    = '0;
               frame_done_in = frame_end;
               ch_sum_in     = sum_new;
               if (start_step) begin
                  dv_in      = DV_W'(cfg_src_ff) << F;
                  rem_in     = '0;
                  quo_in     = '0;
                  ovf_in     = 1'b0;
                  div_cnt_in = '0;
                  state_in   = pdlr_pkg::ST_DIV;
               end
               if (frame_end) begin
                  ch_idx_in = '0;
                  fin_in    = req_data.final_frame;
                  if (!start_step) begin
                     state_in = pdlr_pkg::ST_AVG_MUL;
                  end
               end else begin
                  ch_idx_in = idx_new[pdlr_pkg::COUNT_W-1:0];
               end
            end
         end
         pdlr_pkg::ST_DIV: begin
            dv_in      = dv_ff << 1;
            rem_in     = div_rem;
            quo_in     = {quo_ff[STW-2:0], div_ge};
            ovf_in     = ovf_ff | quo_ff[STW-1];
            div_cnt_in = div_cnt_ff + DC_W'(1);
            if (div_cnt_ff == DC_W'(DV_W - 1)) begin
               state_in = pdlr_pkg::ST_DIV_FIN;
            end
         end
         pdlr_pkg::ST_DIV_FIN: begin
            // clamp to [one/MAX_UPSAMPLE, STEP_MAX]; a zero output rate saturates
            if (ovf_ff) begin
               step_in = pdlr_pkg::STEP_MAX;
            end else if (quo_ff < STEP_LO) begin
               step_in = STEP_LO;
            end else begin
               step_in = quo_ff;
            end
            state_in = frame_done_ff ? pdlr_pkg::ST_AVG_MUL : pdlr_pkg::ST_IDLE;
         end
         pdlr_pkg::ST_AVG_MUL: begin
            mul_a     = ch_sum_ff;
            mul_b     = MB'(pdlr_pkg::RECIP_TABLE[cfg_count_ff]);
            ch_sum_in = '0;
            state_in  = pdlr_pkg::ST_AVG_FIN;
         end
         pdlr_pkg::ST_AVG_FIN: begin
            cur_in   = avg_shr[SW-1:0];
            state_in = pdlr_pkg::ST_HOLD;
         end
         pdlr_pkg::ST_HOLD: begin
            // a held downsampled output is released once its frame has arrived
            if (hold_valid_ff && (hold_slack_ff <= ONE)) begin
               emit_req = 1'b1;
               emit_val = hold_value_ff;
            end
            if (!(emit_req && !push_ok)) begin
               if (hold_valid_ff) begin
                  if (hold_slack_ff <= ONE) begin
                     hold_valid_in = 1'b0;
                  end else begin
                     hold_slack_in = hold_slack_ff - ONE;
                     if (fin_ff) begin
                        hold_valid_in = 1'b0;
                     end
                  end
               end
               if (have_prev_ff) begin
                  state_in = pdlr_pkg::ST_INT_MUL;
               end else if (fin_ff) begin
                  state_in = pdlr_pkg::ST_FIN_LOOP;
               end else begin
                  state_in = pdlr_pkg::ST_END;
               end
            end
         end
         pdlr_pkg::ST_INT_MUL: begin
            if (phase_ff < ONE) begin
               mul_a    = {{(pdlr_pkg::SUM_W - SW - 1){diff[SW]}}, diff};
               mul_b    = MB'(phase_ff[F-1:0]);
               state_in = pdlr_pkg::ST_INT_EMIT;
            end else begin
               phase_in = phase_ff - ONE;
               state_in = fin_ff ? pdlr_pkg::ST_FIN_LOOP : pdlr_pkg::ST_END;
            end
         end
         pdlr_pkg::ST_INT_EMIT: begin
            if (need <= TWO_ONE) begin
               emit_req = 1'b1;
               emit_val = interp_val;
               // product register is shared, so a blocked transfer recomputes it
               if (push_ok) begin
                  phase_in = need;
               end
               state_in = pdlr_pkg::ST_INT_MUL;
            end else begin
               // not yet known to exist: keep it until enough frames arrive
               if (!fin_ff) begin
                  hold_valid_in = 1'b1;
                  hold_value_in = interp_val;
                  hold_slack_in = need - TWO_ONE;
               end
               phase_in = need;
               state_in = pdlr_pkg::ST_INT_MUL;
            end
         end
         pdlr_pkg::ST_FIN_LOOP: begin
            // past the last frame the last sample is held
            if ((phase_ff < ONE) && (need <= ONE)) begin
               emit_req = 1'b1;
               emit_val = cur_ff;
               if (push_ok) begin
                  phase_in = need;
               end
            end else begin
               state_in = pdlr_pkg::ST_END;
            end
         end
         pdlr_pkg::ST_END: begin
            if (!pend_valid_ff || out_free) begin
               end_push      = pend_valid_ff;
               pend_valid_in = 1'b0;
               if (fin_ff) begin
                  prev_in       = '0;
                  have_prev_in  = 1'b0;
                  phase_in      = '0;
                  hold_valid_in = 1'b0;
               end else begin
                  prev_in      = cur_ff;
                  have_prev_in = 1'b1;
               end
               state_in = pdlr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdlr_pkg::ST_IDLE;
         end
      endcase

      // pending stage lets the last result of a request carry run_last
      if (emit_req && push_ok
          && (res_cnt_ff < pdlr_pkg::RES_CNT_W'(pdlr_pkg::MAX_RESULTS))) begin
         emit_push     = pend_valid_ff;
         pend_value_in = emit_val;
         pend_valid_in = 1'b1;
         res_cnt_in    = res_cnt_ff + pdlr_pkg::RES_CNT_W'(1);
      end

      if (emit_push || end_push) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.mono_sample = pend_value_ff;
         rsp_data_in.run_last    = end_push;
         rsp_data_in.cue_last    = end_push && fin_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pdlr_pkg::ST_IDLE;
         cfg_count_ff   <= pdlr_pkg::RST_CHANNEL_COUNT;
         cfg_src_ff     <= pdlr_pkg::RST_SOURCE_RATE;
         cfg_out_ff     <= pdlr_pkg::RST_OUTPUT_RATE;
         cfg_sixteen_ff <= pdlr_pkg::RST_SIXTEEN_BIT;
         ch_sum_ff      <= '0;
         ch_idx_ff      <= '0;
         prev_ff        <= '0;
         have_prev_ff   <= 1'b0;
         phase_ff       <= '0;
         hold_valid_ff  <= 1'b0;
         res_cnt_ff     <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ovf_ff         <= 1'b0;
         div_cnt_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         cfg_count_ff   <= cfg_count_in;
         cfg_src_ff     <= cfg_src_in;
         cfg_out_ff     <= cfg_out_in;
         cfg_sixteen_ff <= cfg_sixteen_in;
         ch_sum_ff      <= ch_sum_in;
         ch_idx_ff      <= ch_idx_in;
         prev_ff        <= prev_in;
         have_prev_ff   <= have_prev_in;
         phase_ff       <= phase_in;
         hold_valid_ff  <= hold_valid_in;
         res_cnt_ff     <= res_cnt_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         ovf_ff         <= ovf_in;
         div_cnt_ff     <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      hold_value_ff <= hold_value_in;
      hold_slack_ff <= hold_slack_in;
      fin_ff        <= fin_in;
      frame_done_ff <= frame_done_in;
      cur_ff        <= cur_in;
      pend_value_ff <= pend_value_in;
      dv_ff         <= dv_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      product_ff    <= product_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;

endmodule

### tb/pcm_downmix_linear_resampler_tb.sv
`timescale 1ns / 100ps

module pcm_downmix_linear_resampler_tb;

   localparam int PHASE_FRAC_BITS = 16;
   localparam int MAX_UPSAMPLE    = 8;
   localparam int PHASE_W         = pdlr_pkg::STEP_W + 1;
   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
   localparam int STEP_FLOOR      = (1 << PHASE_FRAC_BITS) / MAX_UPSAMPLE;
   localparam int PHASE_COUNT     = 9;
   localparam int ITEMS_PER_PHASE = 34;
   localparam int IDLE_SETTLE     = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int TIMEOUT_NS      = 5_000_000;

   // Expected-output store plus a bit-true copy of the downmix/resample datapath
   class mono_resample_scoreboard;
      logic [pdlr_pkg::COUNT_W-1:0]         cfg_channels;
      logic [pdlr_pkg::RATE_W-1:0]          cfg_source;
      logic [pdlr_pkg::RATE_W-1:0]          cfg_output;
      logic                                 cfg_sixteen;
      logic signed [pdlr_pkg::SUM_W-1:0]    chan_sum;
      logic [pdlr_pkg::COUNT_W-1:0]         chan_idx;
      logic signed [pdlr_pkg::SAMPLE_W-1:0] prev_mono;
      logic                                 have_prev;
      logic [PHASE_W-1:0]                   phase_acc;
      logic [pdlr_pkg::STEP_W-1:0]          step_q;
      logic                                 hold_valid;
      logic signed [pdlr_pkg::SAMPLE_W-1:0] hold_value;
      logic [PHASE_W-1:0]                   hold_slack;
      pdlr_pkg::rsp_type                    frame_results[$];
      pdlr_pkg::rsp_type                    expected_mono[$];
      int                                   errors;
      int                                   inputs_noted;
      int                                   results_checked;
      int                                   cues_closed;

      function new();
         cfg_channels    = pdlr_pkg::RST_CHANNEL_COUNT;
         cfg_source      = pdlr_pkg::RST_SOURCE_RATE;
         cfg_output      = pdlr_pkg::RST_OUTPUT_RATE;
         cfg_sixteen     = pdlr_pkg::RST_SIXTEEN_BIT;
         errors          = 0;
         inputs_noted    = 0;
         results_checked = 0;
         cues_closed     = 0;
         clear_cue();
         step_q = calc_step();
      endfunction

      function void clear_cue();
         chan_sum   = '0;
         chan_idx   = '0;
         prev_mono  = '0;
         have_prev  = 1'b0;
         phase_acc  = '0;
         hold_valid = 1'b0;
         hold_value = '0;
         hold_slack = '0;
      endfunction

      function logic [pdlr_pkg::STEP_W-1:0] calc_step();
         logic [pdlr_pkg::RATE_W+PHASE_FRAC_BITS-1:0] quot;
         if (cfg_output == '0) return pdlr_pkg::STEP_MAX;
         quot = {cfg_source, {PHASE_FRAC_BITS{1'b0}}} / cfg_output;
         if (quot < STEP_FLOOR) return pdlr_pkg::STEP_W'(STEP_FLOOR);
         if (quot > pdlr_pkg::STEP_MAX) return pdlr_pkg::STEP_MAX;
         return quot[pdlr_pkg::STEP_W-1:0];
      endfunction

      // a + (b-a)*frac, product truncated toward zero
      function logic signed [pdlr_pkg::SAMPLE_W-1:0] interp(
            logic signed [pdlr_pkg::SAMPLE_W-1:0] a,
            logic signed [pdlr_pkg::SAMPLE_W-1:0] b,
            logic [PHASE_W-1:0] frac);
         longint d;
         longint r;
         d = longint'(b) - longint'(a);
         r = longint'(a) + (d * longint'(frac)) / longint'(PHASE_ONE);
         return pdlr_pkg::SAMPLE_W'(r);
      endfunction

      function void add_result(logic signed [pdlr_pkg::SAMPLE_W-1:0] v);
         pdlr_pkg::rsp_type r;
         if (frame_results.size() >= pdlr_pkg::MAX_RESULTS) return;
         r.mono_sample = v;
         r.run_last    = 1'b0;
         r.cue_last    = 1'b0;
         frame_results = {frame_results, r};
      endfunction

      function void write_register(pdlr_pkg::reg_idx_type idx,
                                   logic [pdlr_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            pdlr_pkg::REG_CHANNEL_COUNT: cfg_channels = value[pdlr_pkg::COUNT_W-1:0];
            pdlr_pkg::REG_SOURCE_RATE:   cfg_source   = value[pdlr_pkg::RATE_W-1:0];
            pdlr_pkg::REG_OUTPUT_RATE:   cfg_output   = value[pdlr_pkg::RATE_W-1:0];
            pdlr_pkg::REG_SIXTEEN_BIT:   cfg_sixteen  = value[0];
            default: ;
         endcase
      endfunction

      function int outstanding();
         return expected_mono.size();
      endfunction

      function void note_sample(pdlr_pkg::req_type item);
         logic signed [pdlr_pkg::SUM_W-1:0]    s;
         logic signed [pdlr_pkg::SAMPLE_W-1:0] cur;
         logic signed [pdlr_pkg::SAMPLE_W-1:0] v;
         logic [PHASE_W-1:0]                   need;
         logic                                 fin;
         int                                   avg;
         int                                   n;
         inputs_noted++;
         fin = item.final_frame;
         if (cfg_channels == '0 || cfg_source == '0) return;
         // step is latched on the first sample of each cue
         if (!have_prev && chan_idx == '0) step_q = calc_step();
         if (cfg_sixteen)
            s = {{(pdlr_pkg::SUM_W-pdlr_pkg::SAMPLE_W){item.sample_raw[pdlr_pkg::SAMPLE_W-1]}},
                 item.sample_raw};
         else
            s = pdlr_pkg::SUM_W'((int'(item.sample_raw[7:0]) - 128) * 256);
         chan_sum = chan_sum + s;
         chan_idx = chan_idx + 1'b1;
         if (chan_idx < cfg_channels) return;

         avg      = int'(chan_sum) / int'(cfg_channels);
         cur      = pdlr_pkg::SAMPLE_W'(avg);
         chan_sum = '0;
         chan_idx = '0;

         // a held downsampled output is released once enough frames prove it
         if (hold_valid) begin
            if (hold_slack <= PHASE_ONE) begin
               add_result(hold_value);
               hold_valid = 1'b0;
            end else begin
               hold_slack = hold_slack - PHASE_ONE;
               if (fin) hold_valid = 1'b0;
            end
         end

         if (have_prev) begin
            while (phase_acc < PHASE_ONE) begin
               need = phase_acc + step_q;
               v    = interp(prev_mono, cur, phase_acc);
               if (need <= 2 * PHASE_ONE) begin
                  add_result(v);
               end else if (!fin) begin
                  hold_valid = 1'b1;
                  hold_value = v;
                  hold_slack = need - 2 * PHASE_ONE;
               end
               phase_acc = need;
            end
            phase_acc = phase_acc - PHASE_ONE;
         end

         if (fin) begin
            // past the last frame the last sample is held
            while (phase_acc < PHASE_ONE) begin
               need = phase_acc + step_q;
               if (need > PHASE_ONE) break;
               add_result(cur);
               phase_acc = need;
            end
            n = frame_results.size();
            if (n > 0) frame_results[n-1].cue_last = 1'b1;
            cues_closed++;
            clear_cue();
         end else begin
            prev_mono = cur;
            have_prev = 1'b1;
         end

         n = frame_results.size();
         if (n > 0) frame_results[n-1].run_last = 1'b1;
         expected_mono = {expected_mono, frame_results};
         frame_results.delete();
      endfunction

      function void check_mono(pdlr_pkg::rsp_type got);
         pdlr_pkg::rsp_type want;
         if (expected_mono.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: expected none, actual %0d/%0b/%0b",
                     $time, got.mono_sample, got.run_last, got.cue_last);
            return;
         end
         want = expected_mono.pop_front();
         results_checked++;
         if (got.mono_sample !== want.mono_sample) begin
            errors++;
            $display("%0t: mono_sample expected %0d actual %0d",
                     $time, want.mono_sample, got.mono_sample);
         end
         if (got.run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b actual %0b",
                     $time, want.run_last, got.run_last);
         end
         if (got.cue_last !== want.cue_last) begin
            errors++;
            $display("%0t: cue_last expected %0b actual %0b",
                     $time, want.cue_last, got.cue_last);
         end
      endfunction
   endclass

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   pdlr_pkg::req_type               req_data    = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   pdlr_pkg::rsp_type               rsp_data;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [pdlr_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [pdlr_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [pdlr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   mono_resample_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit pressure_due  = 1'b0;

   pcm_downmix_linear_resampler #(
      .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
      .MAX_UPSAMPLE(MAX_UPSAMPLE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timed out with %0d results outstanding", sb.outstanding());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_sample(req_data);
         if (rsp_valid && rsp_ready) sb.check_mono(rsp_data);
      end
   end

   // receiver: random stalls, plus one long hold-off counted here
   initial begin : rsp_side
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_due && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // all driving tasks start and end on a falling edge
   task automatic send_item(pdlr_pkg::req_type item);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(pdlr_pkg::reg_idx_type idx,
                            logic [pdlr_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready) break;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.write_register(idx, value);
      @(negedge clock);
   endtask

   task automatic apply_setting(int unsigned ch, int unsigned src, int unsigned outr,
                                int unsigned six);
      csr_write(pdlr_pkg::REG_CHANNEL_COUNT, ch);
      csr_write(pdlr_pkg::REG_SOURCE_RATE, src);
      csr_write(pdlr_pkg::REG_OUTPUT_RATE, outr);
      csr_write(pdlr_pkg::REG_SIXTEEN_BIT, six);
   endtask

   function automatic logic [pdlr_pkg::SAMPLE_W-1:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return {8'($urandom), 8'h00};
         3: return {8'($urandom), 8'hFF};
         4: return 16'h0000;
         5: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // whole frames; stray final flags on non-closing samples are noise
   task automatic send_cue(int frames);
      int unsigned       ch;
      pdlr_pkg::req_type item;
      ch = sb.cfg_channels;
      for (int f = 0; f < frames; f++) begin
         for (int c = 0; c < ch; c++) begin
            item.sample_raw = pick_raw();
            if (c == ch - 1)
               item.final_frame = (f == frames - 1);
            else if (f == frames - 1)
               item.final_frame = ($urandom_range(0, 4) != 0);
            else
               item.final_frame = ($urandom_range(0, 9) == 0);
            send_item(item);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned ch;
      int unsigned src;
      int unsigned outr;
      int unsigned six;
      int unsigned hi;
      int          max_frames;
      int          phase_start;
      int          settings_used;
      sb = new();
      settings_used = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: mono, 16-bit, 2/3 step; full-scale values
      send_item(pdlr_pkg::req_type'{16'h7FFF, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h0000, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h8000, 1'b0});
      send_item(pdlr_pkg::req_type'{16'hFFFF, 1'b1});
      wait_idle();

      // stereo unsigned bytes; upper bits must be ignored
      apply_setting(2, 48000, 48000, 0);
      settings_used++;
      send_item(pdlr_pkg::req_type'{16'hAB00, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h12FF, 1'b1});
      send_item(pdlr_pkg::req_type'{16'hFF80, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h0001, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h55FF, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h0000, 1'b1});
      wait_idle();

      // channel count lowered partway through a frame
      apply_setting(3, 48000, 48000, 1);
      settings_used++;
      send_item(pdlr_pkg::req_type'{16'h4000, 1'b0});
      wait_idle();
      csr_write(pdlr_pkg::REG_CHANNEL_COUNT, 2);
      send_item(pdlr_pkg::req_type'{16'h2000, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h8000, 1'b1});
      send_item(pdlr_pkg::req_type'{16'h8000, 1'b1});
      wait_idle();

      // slowest step: the final frame yields nothing
      apply_setting(1, 262143, 8000, 1);
      settings_used++;
      send_item(pdlr_pkg::req_type'{16'h1234, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h7FFF, 1'b1});
      wait_idle();
      // step of eighteen frames: held output dropped on the final frame
      csr_write(pdlr_pkg::REG_SOURCE_RATE, 144000);
      send_item(pdlr_pkg::req_type'{16'h0100, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h7000, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h9000, 1'b1});
      wait_idle();
      // step of twenty-one frames: held output dropped at cue end
      csr_write(pdlr_pkg::REG_SOURCE_RATE, 168000);
      send_item(pdlr_pkg::req_type'{16'h0100, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h7000, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h9000, 1'b1});
      wait_idle();

      // step clamped at one eighth: sixteen results from the final frame
      apply_setting(1, 1, 192000, 1);
      settings_used++;
      send_item(pdlr_pkg::req_type'{16'h7FFF, 1'b0});
      send_item(pdlr_pkg::req_type'{16'h8000, 1'b1});
      wait_idle();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         max_frames = 10;
         case (p)
            0: begin ch = 1; src = 48000;  outr = 48000;  six = 1; end
            1: begin ch = 7; src = 44100;  outr = 48000;  six = 0; end
            2: begin ch = 2; src = 1;      outr = 192000; six = 1; end
            3: begin ch = 1; src = 262143; outr = 8000;   six = 1; max_frames = 70; end
            4: begin ch = 3; src = 22050;  outr = 96000;  six = 1; end
            default: begin
               ch   = $urandom_range(1, 7);
               six  = $urandom_range(0, 1);
               outr = $urandom_range(8000, 192000);
               if ($urandom_range(0, 3) == 0) begin
                  src = $urandom_range(1, 262143);
               end else begin
                  hi  = (outr * 2 > 262143) ? 262143 : outr * 2;
                  src = $urandom_range(outr / 4, hi);
               end
               max_frames = 6 + 2 * (src / outr);
               if (max_frames * ch > 120) max_frames = 120 / ch;
            end
         endcase
         apply_setting(ch, src, outr, six);
         settings_used++;
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         // long receiver hold-off while the sender keeps offering
         if (p == 4) pressure_due = 1'b1;
         phase_start = sb.inputs_noted;
         while (sb.inputs_noted - phase_start < ITEMS_PER_PHASE)
            send_cue($urandom_range(1, max_frames));
         wait_idle();
      end

      $display("Covered %0d settings, %0d sample transfers and %0d cues.",
               settings_used, sb.inputs_noted, sb.cues_closed);
      $display("Checked %0d mono results; %0d mismatches.",
               sb.results_checked, sb.errors);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/pdlr_pkg.sv
hw/rtl/pcm_downmix_linear_resampler.sv
tb/pcm_downmix_linear_resampler_tb.sv
